@@ hw/rtl/cordic_pkg.sv @@
`timescale 1ns / 1ps

package cordic_pkg;

	localparam int FRAC_BITS_DEF      = 28;
	localparam int MAX_ITERATIONS_DEF = 32;

	localparam int CFG_W     = 6;
	localparam int IN_W      = 32;
	localparam int MAG_W     = 31;
	localparam int ANGLE_W   = 32;

	// x grows by at most 1.65 * sqrt(2) from a 31-bit start: 33 bits plus sign and margin
	localparam int XW        = 35;
	// accumulated angle plus pi stays below 2^33 for FRAC_BITS <= 29
	localparam int ZW        = 34;

	localparam logic [CFG_W-1:0] ITER_RESET = CFG_W'(24);

	localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
	localparam int          GAIN_W      = 30;
	localparam logic [GAIN_W-1:0] GAIN_INV = GAIN_W'(652032874);

	typedef struct packed {
		logic                 negate;
		logic                 from_pi;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_t;

	// arctan(2^-i) rounded half up at frac fraction bits, from a Q62 series.
	// Elaboration time only.
	function automatic logic [63:0] atan_step(input int unsigned i, input int unsigned frac);
		logic [63:0] q;
		logic [63:0] acc;
		logic [63:0] term;
		int unsigned e;
		int unsigned d;
		q   = '0;
		acc = '0;
		if (i == 0) begin
			q = PI_Q60;
		end else begin
			for (int unsigned k = 0; k < 63; k++) begin
				d = 2 * k + 1;
				e = i * d;
				if (e <= 62) begin
					term = (64'd1 << (62 - e)) / 64'(d);
					acc  = k[0] ? (acc - term) : (acc + term);
				end
			end
			q = acc;
		end
		return (q + (64'd1 << (61 - frac))) >> (62 - frac);
	endfunction

	function automatic logic [63:0] pi_fixed(input int unsigned frac);
		return (PI_Q60 + (64'd1 << (59 - frac))) >> (60 - frac);
	endfunction

endpackage

@@ hw/rtl/cordic_stage.sv @@
`timescale 1ns / 1ps

module cordic_stage #(
	parameter int SHIFT = 0,
	parameter logic signed [cordic_pkg::ZW-1:0] ANGLE = '0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  cordic_pkg::vec_t   in_vec,
	input  logic               enable,
	output logic               out_valid,
	output cordic_pkg::vec_t   out_vec
);
	import cordic_pkg::*;

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;
	vec_t                 nxt;

	assign dx = in_vec.y >>> SHIFT;
	assign dy = in_vec.x >>> SHIFT;

	always_comb begin
		nxt = in_vec;
		if (enable) begin
			if (!in_vec.y[XW-1]) begin
				nxt.x = in_vec.x + dx;
				nxt.y = in_vec.y - dy;
				nxt.z = in_vec.z + ANGLE;
			end else begin
				nxt.x = in_vec.x - dx;
				nxt.y = in_vec.y + dy;
				nxt.z = in_vec.z - ANGLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_vec <= nxt;
	end

endmodule

@@ hw/rtl/cordic_atan2_magnitude_core.sv @@
// CORDIC vectoring core: atan2(y, x) and magnitude of a signed fixed-point vector.
// Throughput: one item per cycle; busy stays low and results cannot be held off.
// One register stage per micro-rotation sets the depth; the gain multiply takes two.
// Reset (arst_n low) clears all valid bits and sets iteration_count to 24.
`timescale 1ns / 1ps

module cordic_atan2_magnitude_core #(
	parameter int FRAC_BITS      = cordic_pkg::FRAC_BITS_DEF,
	parameter int MAX_ITERATIONS = cordic_pkg::MAX_ITERATIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// item input
	input  logic                              start,
	output logic                              busy,
	input  logic signed [cordic_pkg::IN_W-1:0] y_in,
	input  logic signed [cordic_pkg::IN_W-1:0] x_in,
	// results, one cycle strobe
	output logic                              result_valid,
	output logic [cordic_pkg::MAG_W-1:0]      magnitude,
	output logic signed [cordic_pkg::ANGLE_W-1:0] angle,
	// iteration_count write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cordic_pkg::CFG_W-1:0]      cfg_data
);
	import cordic_pkg::*;

	localparam int LAT = MAX_ITERATIONS + 3;
	localparam logic signed [ZW-1:0] PI_Z = ZW'(pi_fixed(FRAC_BITS));
	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
	// x split for two narrow partial products
	localparam int XM_W  = 33;
	localparam int LO_W  = 17;
	localparam int HI_W  = XM_W - LO_W;
	localparam int PLO_W = LO_W + GAIN_W;
	localparam int PHI_W = HI_W + GAIN_W;

	// |v| with the most negative value clamped to 2^31-1
	function automatic logic [MAG_W-1:0] abs_clamp(input logic signed [IN_W-1:0] v);
		logic [IN_W:0] m;
		m = v[IN_W-1] ? ((IN_W+1)'(0) - {v[IN_W-1], v}) : {1'b0, v};
		return (m > (IN_W+1)'(MAG_MAX)) ? MAG_MAX : m[MAG_W-1:0];
	endfunction

	// never stalls; config is always taken (the user must write it only while idle; the block does not enforce this)
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	logic [CFG_W-1:0] iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= ITER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			iter_q <= cfg_data;
		end
	end

	// ---- stage 1: sign capture and absolute values
	logic valid_s1;
	vec_t vec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1.negate  <= y_in[IN_W-1];
		vec_s1.from_pi <= x_in[IN_W-1];
		vec_s1.x       <= XW'(abs_clamp(x_in));
		vec_s1.y       <= XW'(abs_clamp(y_in));
		vec_s1.z       <= '0;
	end

	// ---- rotation stages: stage i rotates by arctan(2^-i) while i < iteration_count.
	// A count above MAX_ITERATIONS simply enables every stage.
	vec_t                  chain_vec   [0:MAX_ITERATIONS];
	logic [MAX_ITERATIONS:0] chain_valid;

	assign chain_vec[0]   = vec_s1;
	assign chain_valid[0] = valid_s1;

	for (genvar gi = 0; gi < MAX_ITERATIONS; gi++) begin : g_rot
		localparam logic signed [ZW-1:0] ANG = ZW'(atan_step(gi, FRAC_BITS));
		logic en;
		assign en = iter_q > CFG_W'(gi);

		cordic_stage #(
			.SHIFT (gi),
			.ANGLE (ANG)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[gi]),
			.in_vec    (chain_vec[gi]),
			.enable    (en),
			.out_valid (chain_valid[gi+1]),
			.out_vec   (chain_vec[gi+1])
		);
	end

	// ---- stage 2 (after rotations): quadrant fix and gain partial products
	vec_t                     rot;
	logic [XM_W-1:0]          xm;
	logic signed [ZW-1:0]     z_fix;
	logic signed [ZW-1:0]     z_sgn;

	assign rot   = chain_vec[MAX_ITERATIONS];
	assign xm    = rot.x[XM_W-1:0];    // x is non-negative and below 2^33
	assign z_fix = rot.from_pi ? (PI_Z - rot.z) : rot.z;
	assign z_sgn = rot.negate ? -z_fix : z_fix;

	logic                       valid_s2;
	logic signed [ANGLE_W-1:0]  angle_s2;
	logic [PLO_W-1:0]           plo_s2;
	logic [PHI_W-1:0]           phi_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= chain_valid[MAX_ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		angle_s2 <= z_sgn[ANGLE_W-1:0];
		plo_s2   <= PLO_W'(xm[LO_W-1:0]) * PLO_W'(GAIN_INV);
		phi_s2   <= PHI_W'(xm[XM_W-1:LO_W]) * PHI_W'(GAIN_INV);
	end

	// ---- stage 3: sum, round half up at 2^-30, saturate
	logic [63:0]        prod_sum;
	logic [63-GAIN_W:0] mag_full;

	assign prod_sum = {phi_s2, LO_W'(0)} + 64'(plo_s2) + (64'd1 << (GAIN_W - 1));
	assign mag_full = prod_sum[63:GAIN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		angle     <= angle_s2;
		magnitude <= (mag_full > (64-GAIN_W)'(MAG_MAX)) ? MAG_MAX : mag_full[MAG_W-1:0];
	end

	// ---- checks
	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start, LAT))
		else $error("result without an item LAT cycles earlier");

	a_zero_vector_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && $past(x_in == '0 && y_in == '0, LAT)) |-> (magnitude == '0))
		else $error("zero vector gave nonzero magnitude");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |=> result_valid)
		else $error("item lost between product and output stage");

endmodule
